// File: sv/legendre_recurrence_evaluator_defines.svh
// assertion macros shared by the legendre recurrence evaluator modules
`ifndef LEGENDRE_RECURRENCE_EVALUATOR_DEFINES_SVH
`define LEGENDRE_RECURRENCE_EVALUATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LRE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LRE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lre_pkg.sv
// types, constants and coefficient tables of the legendre recurrence evaluator
`default_nettype none

package lre_pkg;

  localparam int MaxDegree = 63;
  localparam int FracBits  = 24;
  localparam int CoefBits  = 30;
  localparam int XFrac     = 30;
  localparam int ShiftX    = CoefBits + XFrac - FracBits;

  localparam int DegW     = 6;
  localparam int DegCount = 1 << DegW;
  localparam int XW       = 32;
  localparam int ValW     = 48;
  localparam int CoefW    = CoefBits + 1;
  localparam int OpAW     = 32;
  localparam int OpBW     = 56;
  localparam int AccW     = OpAW + OpBW;
  localparam int ResW     = 56;
  localparam int TW       = ValW + 1;
  localparam int WW       = 55;

  typedef logic [DegW-1:0]                 deg_t;
  typedef logic [CoefW-1:0]                coef_t;
  typedef logic [DegCount-1:0][CoefW-1:0]  coef_tab_t;

  typedef enum logic [1:0] {
    SH_COEF  = 2'd0,
    SH_X     = 2'd1,
    SH_EXACT = 2'd2
  } shift_e;

  typedef enum logic [2:0] {
    KIND_A_NAT  = 3'd0,
    KIND_B_NAT  = 3'd1,
    KIND_A_UNIT = 3'd2,
    KIND_B_UNIT = 3'd3,
    KIND_C_UNIT = 3'd4
  } coef_kind_e;

  typedef struct packed {
    logic            start;
    logic [OpAW-1:0] a_mag;
    logic [OpBW-1:0] b_mag;
    logic            neg;
    shift_e          mode;
  } mul_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [ResW-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic norm_mode;
    deg_t top_degree;
  } cfg_t;

  localparam logic [ValW-1:0] SatNegMag = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] SatPosMag = {1'b0, {(ValW-1){1'b1}}};

  // floor(sqrt(floor(num * 2^60 / den))), shift-subtract division then bitwise root
  function automatic coef_t frac_sqrt(input logic [31:0] num, input logic [31:0] den);
    logic [95:0] dvd;
    logic [95:0] rem;
    logic [63:0] quo;
    logic [63:0] rad;
    logic [63:0] root;
    logic [63:0] bitv;
    dvd = 96'(num) << 60;
    rem = '0;
    quo = '0;
    for (int i = 95; i >= 0; i--) begin
      rem = {rem[94:0], dvd[i]};
      if (rem >= 96'(den)) begin
        rem = rem - 96'(den);
        if (i < 64) begin
          quo[i] = 1'b1;
        end
      end
    end
    rad  = quo;
    root = '0;
    bitv = 64'(1) << 62;
    for (int k = 0; k < 32; k++) begin
      if (rad >= root + bitv) begin
        rad  = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[CoefW-1:0];
  endfunction

  // round half away from zero on a non-negative value
  function automatic logic [127:0] rnd_shift(input logic [127:0] v, input int sh);
    return (v + (128'(1) << (sh - 1))) >> sh;
  endfunction

  function automatic coef_tab_t build_coef_tab(input coef_kind_e kind);
    coef_tab_t   tab;
    logic [31:0] nn;
    tab = '0;
    for (int n = 2; n < DegCount; n++) begin
      nn = 32'(n);
      case (kind)
        KIND_A_NAT:  tab[n] = frac_sqrt((nn - 1) * (nn - 1), (2 * nn - 1) * (2 * nn - 1));
        KIND_B_NAT:  tab[n] = frac_sqrt((2 * nn - 1) * (2 * nn - 1), nn * nn);
        KIND_A_UNIT: tab[n] = frac_sqrt((nn - 1) * (nn - 1), (2 * nn - 1) * (2 * nn - 3));
        KIND_B_UNIT: tab[n] = frac_sqrt((2 * nn + 1) * (2 * nn - 1), nn * nn);
        KIND_C_UNIT: tab[n] = frac_sqrt(2 * nn + 1, 2 * nn - 1);
        default:     tab[n] = '0;
      endcase
    end
    return tab;
  endfunction

  // per-degree magnitudes, Q.30; the a coefficients are negative
  localparam coef_tab_t CoefANat  = build_coef_tab(KIND_A_NAT);
  localparam coef_tab_t CoefBNat  = build_coef_tab(KIND_B_NAT);
  localparam coef_tab_t CoefAUnit = build_coef_tab(KIND_A_UNIT);
  localparam coef_tab_t CoefBUnit = build_coef_tab(KIND_B_UNIT);
  localparam coef_tab_t CoefCUnit = build_coef_tab(KIND_C_UNIT);

  localparam coef_t CoefOne   = coef_t'(1) << CoefBits;
  localparam coef_t SqrtHalf  = frac_sqrt(32'd1, 32'd2);
  localparam coef_t SqrtThHlf = frac_sqrt(32'd3, 32'd2);
  localparam coef_t SqrtThree = frac_sqrt(32'd3, 32'd1);

  // degree 0 values and degree 1 derivatives are fixed per mode
  localparam logic [ValW-1:0] P0Nat  = ValW'(1) << FracBits;
  localparam logic [ValW-1:0] P0Unit =
    ValW'(rnd_shift(128'(SqrtHalf) << FracBits, CoefBits));
  localparam logic [ValW-1:0] D1Nat  = P0Nat;
  localparam logic [ValW-1:0] D1Unit =
    ValW'(rnd_shift(128'(SqrtThree) * 128'(P0Unit), CoefBits));

endpackage

`default_nettype wire

// File: sv/lre_mul.sv
// shared multiply, round and saturate unit: 32 x 56 bit magnitude product in two passes
`default_nettype none
`include "legendre_recurrence_evaluator_defines.svh"

module lre_mul import lre_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_LO   = 7'b0000010,
    M_HI   = 7'b0000100,
    M_ACC  = 7'b0001000,
    M_RND  = 7'b0010000,
    M_NEG  = 7'b0100000,
    M_FIN  = 7'b1000000
  } mul_state_e;

  mul_state_e             state_q, state_d;
  logic [OpAW-1:0]        a_q, a_d;
  logic [OpBW-1:0]        b_q, b_d;
  logic                   neg_q, neg_d;
  shift_e                 mode_q, mode_d;
  logic [2*OpAW-1:0]      pp_q, pp_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [ResW-1:0]        mag_q, mag_d;
  logic signed [ResW-1:0] res_q, res_d;

  logic [OpAW-1:0]   mul_b;
  logic [2*OpAW-1:0] product;
  logic [AccW-1:0]   half;
  logic [AccW-1:0]   rsum;
  logic [AccW-1:0]   rshift;
  logic [AccW-1:0]   lim;

  // the one multiplier, low chunk of b first, then the high chunk
  always_comb begin
    mul_b   = (state_q == M_LO) ? b_q[OpAW-1:0] : OpAW'(b_q[OpBW-1:OpAW]);
    product = a_q * mul_b;
  end

  always_comb begin
    half   = (mode_q == SH_X) ? (AccW'(1) << (ShiftX - 1)) : (AccW'(1) << (CoefBits - 1));
    rsum   = acc_q + half;
    rshift = (mode_q == SH_X) ? (rsum >> ShiftX) : (rsum >> CoefBits);
    lim    = neg_q ? AccW'(SatNegMag) : AccW'(SatPosMag);
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    neg_d   = neg_q;
    mode_d  = mode_q;
    pp_d    = pp_q;
    acc_d   = acc_q;
    mag_d   = mag_q;
    res_d   = res_q;
    case (state_q)
      M_IDLE, M_FIN: begin
        if (req_i.start) begin
          a_d     = req_i.a_mag;
          b_d     = req_i.b_mag;
          neg_d   = req_i.neg;
          mode_d  = req_i.mode;
          state_d = M_LO;
        end else begin
          state_d = M_IDLE;
        end
      end
      M_LO: begin
        pp_d    = product;
        state_d = M_HI;
      end
      M_HI: begin
        acc_d   = AccW'(pp_q);
        pp_d    = product;
        state_d = M_ACC;
      end
      M_ACC: begin
        acc_d   = acc_q + (AccW'(pp_q) << OpAW);
        state_d = M_RND;
      end
      M_RND: begin
        if (mode_q == SH_EXACT) begin
          mag_d = acc_q[ResW-1:0];
        end else if (rshift > lim) begin
          mag_d = lim[ResW-1:0];
        end else begin
          mag_d = rshift[ResW-1:0];
        end
        state_d = M_NEG;
      end
      M_NEG: begin
        res_d   = neg_q ? -$signed(mag_q) : $signed(mag_q);
        state_d = M_FIN;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    neg_q  <= neg_d;
    mode_q <= mode_d;
    pp_q   <= pp_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = (state_q == M_FIN);
  assign rsp_o.res  = res_q;

  `LRE_ASSERT_IMP(a_start_when_free, req_i.start, state_q == M_IDLE || state_q == M_FIN,
                  "multiply started while a product is in flight")
  `LRE_ASSERT_IMP(a_round_in_range, state_q == M_NEG && mode_q != SH_EXACT,
                  mag_q <= ResW'(SatNegMag), "rounded magnitude beyond 48-bit range")
  `LRE_ASSERT_IMP(a_fin_after_round, state_q == M_FIN, $past(state_q == M_RND, 2),
                  "result presented without a rounding pass")

endmodule

`default_nettype wire

// File: sv/lre_ctrl.sv
// degree sequencer: recurrence state, operand selection and the output register
`default_nettype none
`include "legendre_recurrence_evaluator_defines.svh"

module lre_ctrl import lre_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [XW-1:0]   grid_x_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output deg_t                   degree_o,
  output logic signed [ValW-1:0] poly_value_o,
  output logic signed [ValW-1:0] poly_deriv_o,
  output logic                   last_o,
  output mul_req_t               mul_req_o,
  input  mul_rsp_t               mul_rsp_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_PUSH  = 4'b1000
  } ctrl_state_e;

  // products of one degree: x*coef for degree 1, then the six of the recurrence
  typedef enum logic [2:0] {
    STEP_D1  = 3'd0,
    STEP_AP2 = 3'd1,
    STEP_XP1 = 3'd2,
    STEP_BT  = 3'd3,
    STEP_NP1 = 3'd4,
    STEP_XD1 = 3'd5,
    STEP_CW  = 3'd6
  } step_e;

  ctrl_state_e            state_q, state_d;
  step_e                  step_q, step_d;
  deg_t                   n_q, n_d;
  logic signed [XW-1:0]   x_q, x_d;
  logic signed [ValW-1:0] p1_q, p1_d;
  logic signed [ValW-1:0] p2_q, p2_d;
  logic signed [ValW-1:0] d1_q, d1_d;
  logic signed [TW-1:0]   t_q, t_d;
  logic signed [WW-1:0]   w_q, w_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic signed [ValW-1:0] der_q, der_d;

  logic                   out_valid_q, out_valid_d;
  deg_t                   deg_out_q;
  logic signed [ValW-1:0] value_out_q;
  logic signed [ValW-1:0] deriv_out_q;
  logic                   last_out_q;

  logic                   out_free;
  logic                   push;
  logic                   is_last;
  logic                   start;
  logic [OpAW-1:0]        ax_mag;
  logic [OpAW-1:0]        sel_a;
  logic                   sign_a;
  logic signed [OpBW-1:0] sel_b;
  logic [OpBW-1:0]        b_mag;
  shift_e                 mode;

  assign out_free = !out_valid_q || !out_stall_i;
  assign push     = (state_q == S_PUSH) && out_free;
  assign is_last  = (n_q == cfg_i.top_degree);

  // operand selection for the current product
  always_comb begin
    ax_mag = x_q[XW-1] ? (~x_q + 32'd1) : x_q;
    sel_a  = '0;
    sign_a = 1'b0;
    sel_b  = '0;
    mode   = SH_COEF;
    case (step_q)
      STEP_D1: begin
        sel_a = cfg_i.norm_mode ? OpAW'(SqrtThHlf) : OpAW'(CoefOne);
        sel_b = OpBW'(x_q);
        mode  = SH_X;
      end
      STEP_AP2: begin
        sel_a  = cfg_i.norm_mode ? OpAW'(CoefAUnit[n_q]) : OpAW'(CoefANat[n_q]);
        sign_a = 1'b1;
        sel_b  = OpBW'(p2_q);
      end
      STEP_XP1: begin
        sel_a  = ax_mag;
        sign_a = x_q[XW-1];
        sel_b  = OpBW'(p1_q);
      end
      STEP_BT: begin
        sel_a = cfg_i.norm_mode ? OpAW'(CoefBUnit[n_q]) : OpAW'(CoefBNat[n_q]);
        sel_b = OpBW'(t_q);
      end
      STEP_NP1: begin
        sel_a = OpAW'(n_q);
        sel_b = OpBW'(p1_q);
        mode  = SH_EXACT;
      end
      STEP_XD1: begin
        sel_a  = ax_mag;
        sign_a = x_q[XW-1];
        sel_b  = OpBW'(d1_q);
      end
      STEP_CW: begin
        sel_a = cfg_i.norm_mode ? OpAW'(CoefCUnit[n_q]) : OpAW'(CoefOne);
        sel_b = OpBW'(w_q);
      end
      default: begin
        sel_a = '0;
        sel_b = '0;
      end
    endcase
    b_mag = sel_b[OpBW-1] ? OpBW'(-sel_b) : OpBW'(sel_b);
  end

  always_comb begin
    mul_req_o.start = start;
    mul_req_o.a_mag = sel_a;
    mul_req_o.b_mag = b_mag;
    mul_req_o.neg   = sign_a ^ sel_b[OpBW-1];
    mul_req_o.mode  = mode;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    n_d     = n_q;
    x_d     = x_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    d1_d    = d1_q;
    t_d     = t_q;
    w_d     = w_q;
    val_d   = val_q;
    der_d   = der_q;
    start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d     = grid_x_i;
          n_d     = '0;
          val_d   = cfg_i.norm_mode ? $signed(P0Unit) : $signed(P0Nat);
          der_d   = '0;
          state_d = S_PUSH;
        end
      end
      S_START: begin
        start   = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mul_rsp_i.done) begin
          state_d = S_START;
          case (step_q)
            STEP_D1: begin
              val_d   = mul_rsp_i.res[ValW-1:0];
              der_d   = cfg_i.norm_mode ? $signed(D1Unit) : $signed(D1Nat);
              state_d = S_PUSH;
            end
            STEP_AP2: begin
              t_d    = mul_rsp_i.res[TW-1:0];
              step_d = STEP_XP1;
            end
            STEP_XP1: begin
              t_d    = t_q + $signed(mul_rsp_i.res[TW-1:0]);
              step_d = STEP_BT;
            end
            STEP_BT: begin
              val_d  = mul_rsp_i.res[ValW-1:0];
              step_d = STEP_NP1;
            end
            STEP_NP1: begin
              w_d    = mul_rsp_i.res[WW-1:0];
              step_d = STEP_XD1;
            end
            STEP_XD1: begin
              w_d    = w_q + $signed(mul_rsp_i.res[WW-1:0]);
              step_d = STEP_CW;
            end
            STEP_CW: begin
              der_d   = mul_rsp_i.res[ValW-1:0];
              state_d = S_PUSH;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        if (out_free) begin
          p2_d = p1_q;
          p1_d = val_q;
          d1_d = der_q;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            n_d     = n_q + deg_t'(1);
            step_d  = (n_q == '0) ? STEP_D1 : STEP_AP2;
            state_d = S_START;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_D1;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    d1_q  <= d1_d;
    t_q   <= t_d;
    w_q   <= w_d;
    val_q <= val_d;
    der_q <= der_d;
    if (push) begin
      deg_out_q   <= n_q;
      value_out_q <= val_q;
      deriv_out_q <= der_q;
      last_out_q  <= is_last;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign degree_o     = deg_out_q;
  assign poly_value_o = value_out_q;
  assign poly_deriv_o = deriv_out_q;
  assign last_o       = last_out_q;

  `LRE_ASSERT_NXT(a_accept_to_deg0, in_valid_i && !in_stall_o,
                  state_q == S_PUSH && n_q == '0, "accepted point did not start at degree 0")
  `LRE_ASSERT_IMP(a_done_while_waiting, mul_rsp_i.done, state_q == S_WAIT,
                  "product finished while the sequencer was not waiting")
  `LRE_ASSERT_NXT(a_last_frees_input, push && is_last, state_q == S_IDLE && !in_stall_o,
                  "sequencer busy after the top degree was delivered")

endmodule

`default_nettype wire

// File: sv/legendre_recurrence_evaluator.sv
// top level: configuration registers, degree sequencer and shared multiply unit
// degree 0 needs no product, degree 1 one product and each higher degree six products
// the next point can be taken in the cycle after a run's last beat is loaded; the multiply unit sets the pace
// output register holds one beat, so a stalled output only pauses the sequencer
// reset (async, active low) clears control; norm_mode resets to 0 and max_degree to 63
`default_nettype none

module legendre_recurrence_evaluator import lre_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [DegW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [XW-1:0]   grid_x_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DegW-1:0]        degree_o,
  output logic signed [ValW-1:0] poly_value_o,
  output logic signed [ValW-1:0] poly_deriv_o,
  output logic                   last_o
);

  localparam logic CfgNormMode  = 1'b0;
  localparam logic CfgMaxDegree = 1'b1;

  localparam deg_t TopCap = (MaxDegree > DegCount - 1) ? deg_t'(DegCount - 1)
                                                       : deg_t'(MaxDegree);

  logic     norm_mode_q, norm_mode_d;
  deg_t     max_degree_q, max_degree_d;
  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  always_comb begin
    norm_mode_d  = norm_mode_q;
    max_degree_d = max_degree_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgNormMode:  norm_mode_d  = cfg_wdata_i[0];
        CfgMaxDegree: max_degree_d = cfg_wdata_i;
        default:      norm_mode_d  = norm_mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q  <= 1'b0;
      max_degree_q <= deg_t'(DegCount - 1);
    end else begin
      norm_mode_q  <= norm_mode_d;
      max_degree_q <= max_degree_d;
    end
  end

  always_comb begin
    cfg.norm_mode  = norm_mode_q;
    cfg.top_degree = (max_degree_q > TopCap) ? TopCap : max_degree_q;
  end

  lre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .grid_x_i    (grid_x_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .degree_o    (degree_o),
    .poly_value_o(poly_value_o),
    .poly_deriv_o(poly_deriv_o),
    .last_o      (last_o),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp)
  );

  lre_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for the legendre recurrence evaluator
`default_nettype none

module tb_top;
  import lre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {
    CFG_NORM_MODE  = 1'b0,
    CFG_MAX_DEGREE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [DegW-1:0]        degree;
    logic signed [ValW-1:0] value;
    logic signed [ValW-1:0] deriv;
    logic                   last;
  } leg_beat_t;

  // cfg: write both registers before the point; typed: natural mode, top degree 0 or 1
  typedef struct packed {
    logic            cfg;
    logic [DegW-1:0] mode_wd;
    logic [DegW-1:0] deg_wd;
    logic [XW-1:0]   x;
    logic            typed;
    logic [ValW-1:0] p1_exp;
  } dir_row_t;

  localparam longint OneQ24    = longint'(1) << FracBits;
  localparam int     IdleLimit = 5000;
  localparam int     NumRows   = 21;

  localparam dir_row_t DirectedRows [NumRows] = '{
    '{1'b0, 6'h00, 6'h00, 32'h0000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b0, 6'h00, 6'h00, 32'h4000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b1, 6'h00, 6'h00, 32'h0000_0000, 1'b1, 48'h0000_0000_0000},
    '{1'b0, 6'h00, 6'h00, 32'h8000_0000, 1'b1, 48'h0000_0000_0000},
    '{1'b1, 6'h00, 6'h01, 32'h4000_0000, 1'b1, 48'h0000_0100_0000},
    '{1'b0, 6'h00, 6'h01, 32'hC000_0000, 1'b1, 48'hFFFF_FF00_0000},
    '{1'b0, 6'h00, 6'h01, 32'h7FFF_FFFF, 1'b1, 48'h0000_0200_0000},
    '{1'b0, 6'h00, 6'h01, 32'h8000_0000, 1'b1, 48'hFFFF_FE00_0000},
    '{1'b0, 6'h00, 6'h01, 32'h0000_0000, 1'b1, 48'h0000_0000_0000},
    '{1'b0, 6'h00, 6'h01, 32'h0000_0001, 1'b1, 48'h0000_0000_0000},
    // half an lsb rounds away from zero
    '{1'b0, 6'h00, 6'h01, 32'h0000_0020, 1'b1, 48'h0000_0000_0001},
    '{1'b0, 6'h00, 6'h01, 32'hFFFF_FFE0, 1'b1, 48'hFFFF_FFFF_FFFF},
    // unit mode, upper write bits set and ignored
    '{1'b1, 6'h3F, 6'h01, 32'h4000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b0, 6'h3F, 6'h01, 32'hC000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b1, 6'h01, 6'h3F, 32'h4000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b0, 6'h01, 6'h3F, 32'h7FFF_FFFF, 1'b0, 48'h0000_0000_0000},
    '{1'b0, 6'h01, 6'h3F, 32'h8000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b1, 6'h3E, 6'h3F, 32'h7FFF_FFFF, 1'b0, 48'h0000_0000_0000},
    '{1'b0, 6'h3E, 6'h3F, 32'hC000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b1, 6'h00, 6'h05, 32'h2000_0000, 1'b0, 48'h0000_0000_0000},
    '{1'b1, 6'h01, 6'h05, 32'hE000_0000, 1'b0, 48'h0000_0000_0000}
  };

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_index_i = 1'b0;
  logic [DegW-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic signed [XW-1:0]   grid_x_i    = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [DegW-1:0]        degree_o;
  logic signed [ValW-1:0] poly_value_o;
  logic signed [ValW-1:0] poly_deriv_o;
  logic                   last_o;

  // mirror of the registers
  logic            cur_unit       = 1'b0;
  logic [DegW-1:0] cur_top_degree = 6'd63;

  leg_beat_t   expected_beats[$];
  leg_beat_t   head_beat;
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  legendre_recurrence_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .grid_x_i    (grid_x_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .degree_o    (degree_o),
    .poly_value_o(poly_value_o),
    .poly_deriv_o(poly_deriv_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // floor of sqrt(num/den) in Q.30
  function automatic longint root_ratio(input longint num, input longint den);
    logic [127:0] quot;
    logic [63:0]  root;
    logic [63:0]  trial;
    quot = (128'(num) << 60) / 128'(den);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (128'(trial) * 128'(trial) <= quot) begin
        root = trial;
      end
    end
    return longint'(root);
  endfunction

  // exact product, magnitude rounded half away from zero, saturated to 48 bits
  function automatic longint round_mul(input longint lhs, input longint rhs, input int sh);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  lim;
    logic [127:0] prod;
    neg  = (lhs < 0) != (rhs < 0);
    ua   = (lhs < 0) ? 64'(-lhs) : 64'(lhs);
    ub   = (rhs < 0) ? 64'(-rhs) : 64'(rhs);
    prod = (128'(ua) * 128'(ub) + (128'(1) << (sh - 1))) >> sh;
    lim  = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
    if (prod > 128'(lim)) begin
      prod = 128'(lim);
    end
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic void expect_beat(input int n, input longint val, input longint der,
                                      input logic last);
    leg_beat_t beat;
    beat.degree = n[DegW-1:0];
    beat.value  = val[ValW-1:0];
    beat.deriv  = der[ValW-1:0];
    beat.last   = last;
    expected_beats.push_back(beat);
  endfunction

  // all degrees of one grid point under the current register mirror
  function automatic void predict_point(input logic [XW-1:0] x);
    longint xs;
    longint one;
    longint c;
    longint a_mag;
    longint b_mag;
    longint cd;
    longint t;
    longint w;
    longint p_cur;
    longint p_n1;
    longint p_n2;
    longint d_cur;
    longint d_n1;
    int     top;
    xs   = longint'($signed(x));
    top  = int'(cur_top_degree);
    one  = longint'(1) << CoefBits;
    c    = cur_unit ? root_ratio(1, 2) : one;
    p_n1 = round_mul(c, OneQ24, CoefBits);
    p_n2 = 0;
    d_n1 = 0;
    expect_beat(0, p_n1, 0, top == 0);
    if (top >= 1) begin
      c     = cur_unit ? root_ratio(3, 2) : one;
      p_cur = round_mul(c, xs, CoefBits + XFrac - FracBits);
      c     = cur_unit ? root_ratio(3, 1) : one;
      d_cur = round_mul(c, p_n1, CoefBits);
      expect_beat(1, p_cur, d_cur, top == 1);
      p_n2 = p_n1;
      p_n1 = p_cur;
      d_n1 = d_cur;
    end
    for (longint n = 2; n <= top; n++) begin
      if (cur_unit) begin
        a_mag = root_ratio((n - 1) * (n - 1), (2 * n - 1) * (2 * n - 3));
        b_mag = root_ratio((2 * n + 1) * (2 * n - 1), n * n);
        cd    = root_ratio(2 * n + 1, 2 * n - 1);
      end else begin
        a_mag = root_ratio((n - 1) * (n - 1), (2 * n - 1) * (2 * n - 1));
        b_mag = root_ratio((2 * n - 1) * (2 * n - 1), n * n);
        cd    = one;
      end
      t     = round_mul(-a_mag, p_n2, CoefBits) + round_mul(xs, p_n1, XFrac);
      p_cur = round_mul(b_mag, t, CoefBits);
      w     = n * p_n1 + round_mul(xs, d_n1, XFrac);
      d_cur = round_mul(cd, w, CoefBits);
      expect_beat(int'(n), p_cur, d_cur, n == top);
      p_n2 = p_n1;
      p_n1 = p_cur;
      d_n1 = d_cur;
    end
  endfunction

  function automatic void check_field(input string name, input logic [ValW-1:0] want,
                                      input logic [ValW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // holds valid low, then waits until every result of the points sent so far is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_config(input logic [DegW-1:0] mode_wd, input logic [DegW-1:0] deg_wd);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_NORM_MODE;
    cfg_wdata_i <= mode_wd;
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_DEGREE;
    cfg_wdata_i <= deg_wd;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cur_unit       = mode_wd[0];
    cur_top_degree = deg_wd;
  endtask

  // returns at the edge where the beat is taken
  task automatic send_point(input logic [XW-1:0] x);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    grid_x_i   <= x;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat degree %0d value %h deriv %h last %b", $time,
                 degree_o, poly_value_o, poly_deriv_o, last_o);
        mismatch_count++;
      end else begin
        head_beat = expected_beats.pop_front();
        check_field("degree", ValW'(head_beat.degree), ValW'(degree_o));
        check_field("poly_value", head_beat.value, poly_value_o);
        check_field("poly_deriv", head_beat.deriv, poly_deriv_o);
        check_field("last", ValW'(head_beat.last), ValW'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t        row;
    logic            mode;
    logic [DegW-1:0] top;
    logic [XW-1:0]   x;
    int              count;
    int unsigned     pick;

    send_gap_pct   = 12;
    recv_stall_pct = 72;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      row = DirectedRows[r];
      if (row.cfg) begin
        wait_drained();
        set_config(row.mode_wd, row.deg_wd);
      end
      send_point(row.x);
      if (row.typed) begin
        expect_beat(0, OneQ24, 0, cur_top_degree == 0);
        if (cur_top_degree == 1) begin
          expect_beat(1, longint'($signed(row.p1_exp)), OneQ24, 1'b1);
        end
      end else begin
        predict_point(row.x);
      end
    end

    for (int regime = 0; regime < 3; regime++) begin
      for (int ph = 0; ph < 6; ph++) begin
        case (ph)
          0: begin mode = regime[0];  top = 6'd0;  count = 15; end
          1: begin mode = ~regime[0]; top = 6'd1;  count = 15; end
          2: begin mode = 1'b0; top = DegW'($urandom_range(12, 2)); count = 40; end
          3: begin mode = 1'b1; top = DegW'($urandom_range(12, 2)); count = 40; end
          4: begin
            mode  = 1'($urandom_range(1));
            top   = DegW'($urandom_range(40, 13));
            count = 12;
          end
          default: begin mode = regime[0]; top = 6'd63; count = 3; end
        endcase
        wait_drained();
        case (regime)
          0: begin send_gap_pct = 12; recv_stall_pct = 72; end
          1: begin send_gap_pct = 72; recv_stall_pct = 12; end
          default: begin send_gap_pct = 0; recv_stall_pct = 0; end
        endcase
        set_config({5'($urandom_range(31)), mode}, top);
        for (int i = 0; i < count; i++) begin
          pick = $urandom_range(99);
          if (pick < 80) begin
            // within [-1, 1]
            x = XW'($urandom_range(32'h8000_0000) - 32'h4000_0000);
          end else if (pick < 85) begin
            case ($urandom_range(2))
              0: x = 32'h4000_0000;
              1: x = 32'hC000_0000;
              default: x = 32'h0000_0000;
            endcase
          end else begin
            x = $urandom;
          end
          send_point(x);
          predict_point(x);
        end
      end
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/lre_pkg.sv
sv/lre_mul.sv
sv/lre_ctrl.sv
sv/legendre_recurrence_evaluator.sv
verif/tb_top.sv
